@@ hw/rtl/ebc_pkg.sv @@
// ----------------------------------------------------------------------------
// ebc_pkg
// Shared types, opcodes and constants of the eight-bit CPU step engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ebc_pkg;

    localparam int NUM_REGS  = 16;
    localparam int RF_AW     = $clog2(NUM_REGS);
    localparam int MEM_BYTES = 256;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int DATA_W    = 8;

    localparam logic [DATA_W-1:0] SP_RESET = 8'hFF;

    // flag bit positions
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_N = 2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef enum logic [3:0] {
        OP_CTRL  = 4'h0,
        OP_LDI   = 4'h1,
        OP_LD    = 4'h2,
        OP_ST    = 4'h3,
        OP_MOV   = 4'h4,
        OP_ADD   = 4'h5,
        OP_SUB   = 4'h6,
        OP_LOGIC = 4'h7,
        OP_UNARY = 4'h8,
        OP_JUMP  = 4'h9,
        OP_CALL  = 4'hA,
        OP_RET   = 4'hB,
        OP_PUSH  = 4'hC,
        OP_POP   = 4'hD,
        OP_TERM  = 4'hE,
        OP_NOPF  = 4'hF
    } op_t;

    localparam logic [3:0] SUB_HALT = 4'hF;
    localparam logic [3:0] SUB_AND  = 4'h0;
    localparam logic [3:0] SUB_OR   = 4'h1;
    localparam logic [3:0] SUB_XOR  = 4'h2;
    localparam logic [3:0] SUB_NOT  = 4'h0;
    localparam logic [3:0] SUB_INC  = 4'h1;
    localparam logic [3:0] SUB_DEC  = 4'h2;
    localparam logic [3:0] SUB_JMP  = 4'h0;
    localparam logic [3:0] SUB_JZ   = 4'h1;
    localparam logic [3:0] SUB_JNZ  = 4'h2;
    localparam logic [3:0] SUB_JN   = 4'h3;
    localparam logic [3:0] SUB_JC   = 4'h4;
    localparam logic [3:0] SUB_TX   = 4'h0;
    localparam logic [3:0] SUB_RX   = 4'h1;

    // operands gathered for one instruction
    typedef struct packed {
        logic [DATA_W-1:0] b1;
        logic [DATA_W-1:0] b2;
        logic [DATA_W-1:0] ra_val;
        logic [DATA_W-1:0] rb_val;
        logic [DATA_W-1:0] rc_val;
        logic [DATA_W-1:0] memd;
        logic [DATA_W-1:0] data;
        logic [DATA_W-1:0] pc;
        logic [DATA_W-1:0] sp;
        logic [2:0]        flags;
    } exec_in_t;

    // effects of one instruction
    typedef struct packed {
        logic              rf_we;
        logic [RF_AW-1:0]  rf_waddr;
        logic [DATA_W-1:0] rf_wdata;
        logic              mem_we;
        logic [MEM_AW-1:0] mem_waddr;
        logic [DATA_W-1:0] mem_wdata;
        logic [DATA_W-1:0] pc_next;
        logic [DATA_W-1:0] sp_next;
        logic [2:0]        flags_next;
        logic              halt_set;
        logic              char_valid;
        logic [DATA_W-1:0] char_out;
        logic              input_taken;
    } exec_out_t;

    function automatic logic [MEM_AW-1:0] maddr(input logic [DATA_W-1:0] a);
        return a[MEM_AW-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ebc_ram.sv @@
// ----------------------------------------------------------------------------
// ebc_ram
// Generic RAM, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ebc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/ebc_exec.sv @@
// ----------------------------------------------------------------------------
// ebc_exec
// Execute unit: decodes one instruction and computes its write-backs.
// ----------------------------------------------------------------------------
`default_nettype none

module ebc_exec import ebc_pkg::*; (
    input  exec_in_t  ei,
    output exec_out_t eo
);

    logic [3:0]        op_code;
    logic [3:0]        sub;
    logic [8:0]        sum;
    logic [DATA_W-1:0] diff;
    logic [DATA_W-1:0] lres;
    logic [DATA_W-1:0] ures;
    logic [DATA_W-1:0] pc_inc;
    logic              go;

    always_comb begin
        op_code = ei.b1[7:4];
        sub     = ei.b1[3:0];
        pc_inc  = ei.pc + 8'd2;
        sum     = {1'b0, ei.ra_val} + {1'b0, ei.rb_val};
        diff    = ei.ra_val - ei.rb_val;

        case (sub)
            SUB_AND: lres = ei.rb_val & ei.rc_val;
            SUB_OR:  lres = ei.rb_val | ei.rc_val;
            default: lres = ei.rb_val ^ ei.rc_val;
        endcase

        case (sub)
            SUB_NOT: ures = ~ei.rb_val;
            SUB_INC: ures = ei.rb_val + 8'd1;
            default: ures = ei.rb_val - 8'd1;   // wraps to 0xFF from zero
        endcase

        case (sub)
            SUB_JMP: go = 1'b1;
            SUB_JZ:  go = ei.flags[FLAG_Z];
            SUB_JNZ: go = !ei.flags[FLAG_Z];
            SUB_JN:  go = ei.flags[FLAG_N];
            SUB_JC:  go = ei.flags[FLAG_C];
            default: go = 1'b0;
        endcase

        eo             = '0;
        eo.rf_waddr    = ei.b1[RF_AW-1:0];
        eo.mem_waddr   = maddr(ei.b2);
        eo.mem_wdata   = ei.ra_val;
        eo.pc_next     = pc_inc;
        eo.sp_next     = ei.sp;
        eo.flags_next  = ei.flags;

        unique case (op_code)
            OP_CTRL: begin
                eo.halt_set = (sub == SUB_HALT);
            end
            OP_LDI: begin
                eo.rf_we    = 1'b1;
                eo.rf_wdata = ei.b2;
            end
            OP_LD, OP_POP: begin
                eo.rf_we    = 1'b1;
                eo.rf_wdata = ei.memd;
                if (op_code == OP_POP) begin
                    eo.sp_next = ei.sp + 8'd1;
                end
            end
            OP_ST: begin
                eo.mem_we = 1'b1;
            end
            OP_MOV: begin
                eo.rf_we    = 1'b1;
                eo.rf_wdata = ei.rb_val;
            end
            OP_ADD: begin
                eo.rf_we              = 1'b1;
                eo.rf_wdata           = sum[7:0];
                eo.flags_next[FLAG_C] = sum[8];
                eo.flags_next[FLAG_Z] = (sum == 9'd0);
            end
            OP_SUB: begin
                eo.rf_we              = 1'b1;
                eo.rf_wdata           = diff;
                eo.flags_next[FLAG_Z] = (ei.ra_val == ei.rb_val);
                eo.flags_next[FLAG_N] = (ei.ra_val < ei.rb_val);
            end
            OP_LOGIC: begin
                if (sub == SUB_AND || sub == SUB_OR || sub == SUB_XOR) begin
                    eo.rf_we              = 1'b1;
                    eo.rf_waddr           = ei.b2[7:4];
                    eo.rf_wdata           = lres;
                    eo.flags_next[FLAG_Z] = (lres == 8'd0);
                end
            end
            OP_UNARY: begin
                eo.rf_waddr = ei.b2[7:4];
                eo.rf_wdata = ures;
                if (sub == SUB_NOT) begin
                    eo.rf_we              = 1'b1;
                    eo.flags_next[FLAG_Z] = (ures == 8'd0);
                end else if (sub == SUB_INC) begin
                    eo.rf_we              = 1'b1;
                    eo.flags_next[FLAG_C] = (ei.rb_val == 8'hFF);
                end else if (sub == SUB_DEC) begin
                    eo.rf_we              = 1'b1;
                    eo.flags_next[FLAG_N] = (ei.rb_val == 8'd0);
                    eo.flags_next[FLAG_Z] = (ei.rb_val == 8'd1);
                end
            end
            OP_JUMP: begin
                if (go) begin
                    eo.pc_next = ei.rb_val;
                end
            end
            OP_CALL: begin
                eo.mem_we    = 1'b1;
                eo.mem_waddr = maddr(ei.sp);
                eo.mem_wdata = pc_inc;
                eo.sp_next   = ei.sp - 8'd1;
                eo.pc_next   = ei.b2;
            end
            OP_RET: begin
                eo.sp_next = ei.sp + 8'd1;
                eo.pc_next = ei.memd;
            end
            OP_PUSH: begin
                eo.mem_we    = 1'b1;
                eo.mem_waddr = maddr(ei.sp);
                eo.sp_next   = ei.sp - 8'd1;
            end
            OP_TERM: begin
                eo.rf_waddr = ei.b2[7:4];
                eo.rf_wdata = ei.data;
                if (sub == SUB_TX) begin
                    eo.char_valid = 1'b1;
                    eo.char_out   = ei.rb_val;
                end else if (sub == SUB_RX) begin
                    eo.rf_we       = 1'b1;
                    eo.input_taken = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/eight_bit_cpu_step.sv @@
// ----------------------------------------------------------------------------
// eight_bit_cpu_step
// Eight-bit CPU that loads one RAM byte or runs one instruction per transfer.
// ----------------------------------------------------------------------------
// After reset the core sweeps its RAM and register file to zero, one entry a
// cycle, and holds s_tready low meanwhile; the stack pointer write port works
// throughout. A RAM load, or a step on a halted core, completes in S_IDLE.
// An instruction step runs S_FETCH, S_OPER, S_SRC and S_EXEC: the two
// instruction bytes come one after the other through the single read port of
// the RAM, then R[ra], R[rb] and R[rc] through the single read port of the
// register file; S_EXEC executes and writes back. One item waits in an input
// buffer while another executes, and the result register hands off to the
// m_ side without stalling the engine unless it is still full at write-back.
`default_nettype none

module eight_bit_cpu_step import ebc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,    // stack_top
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,        // [7:0] address, [15:8] data
    input  wire logic        s_tuser,        // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata         // [0] char_valid, [8:1] char_out,
                                             // [9] halted, [17:10] pc_now,
                                             // [20:18] flags_now,
                                             // [21] input_taken, [23:22] zero
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_FETCH = 6'b000100,
        S_OPER  = 6'b001000,
        S_SRC   = 6'b010000,
        S_EXEC  = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [MEM_AW-1:0]   clr_cnt_reg;
    logic                in_valid_reg;
    logic                in_cmd_reg;
    logic [DATA_W-1:0]   in_addr_reg;
    logic [DATA_W-1:0]   in_data_reg;
    logic [DATA_W-1:0]   data_reg;
    logic [DATA_W-1:0]   pc_reg;
    logic [DATA_W-1:0]   sp_reg;
    logic [2:0]          flags_reg;
    logic                halt_reg;
    logic [DATA_W-1:0]   b1_reg;
    logic [DATA_W-1:0]   b2_reg;
    logic [DATA_W-1:0]   ra_val_reg;
    logic [DATA_W-1:0]   rb_val_reg;
    logic [DATA_W-1:0]   memd_reg;
    logic                m_tvalid_reg;
    logic [23:0]         m_tdata_reg;

    logic                out_free;
    logic                quick;
    logic                start;
    logic                exec_fire;
    logic                s_xfer;
    logic [23:0]         res_tdata;

    logic                mem_we;
    logic [MEM_AW-1:0]   mem_waddr;
    logic [DATA_W-1:0]   mem_wdata;
    logic [MEM_AW-1:0]   mem_raddr;
    logic [DATA_W-1:0]   mem_rdata;
    logic                rf_we;
    logic [RF_AW-1:0]    rf_waddr;
    logic [DATA_W-1:0]   rf_wdata;
    logic [RF_AW-1:0]    rf_raddr;
    logic [DATA_W-1:0]   rf_rdata;

    exec_in_t            ei;
    exec_out_t           eo;

    ebc_ram #(.WIDTH(DATA_W), .DEPTH(MEM_BYTES)) u_mem (
        .clk   (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ebc_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_rf (
        .clk   (aclk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr),
        .rdata (rf_rdata)
    );

    ebc_exec u_exec (
        .ei (ei),
        .eo (eo)
    );

    assign s_tready = !in_valid_reg && (state_reg != S_CLEAR);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        ei.b1     = b1_reg;
        ei.b2     = b2_reg;
        ei.ra_val = ra_val_reg;
        ei.rb_val = rb_val_reg;
        ei.rc_val = rf_rdata;
        ei.memd   = memd_reg;
        ei.data   = data_reg;
        ei.pc     = pc_reg;
        ei.sp     = sp_reg;
        ei.flags  = flags_reg;
    end

    always_comb begin
        out_free  = !m_tvalid_reg || m_tready;
        quick     = (state_reg == S_IDLE) && in_valid_reg &&
                    ((in_cmd_reg == CMD_LOAD) || halt_reg) && out_free;
        start     = (state_reg == S_IDLE) && in_valid_reg &&
                    (in_cmd_reg == CMD_STEP) && !halt_reg;
        exec_fire = (state_reg == S_EXEC) && out_free;

        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (clr_cnt_reg == MEM_AW'(MEM_BYTES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH: state_next = S_OPER;
            S_OPER:  state_next = S_SRC;
            S_SRC:   state_next = S_EXEC;
            S_EXEC: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase

        // RAM read address follows the fetch and operand sequence
        unique case (state_reg)
            S_IDLE:  mem_raddr = maddr(pc_reg);
            S_FETCH: mem_raddr = maddr(pc_reg + 8'd1);
            S_OPER: begin
                if (b1_reg[7:4] == OP_RET || b1_reg[7:4] == OP_POP) begin
                    mem_raddr = maddr(sp_reg + 8'd1);
                end else begin
                    mem_raddr = maddr(mem_rdata);
                end
            end
            default: mem_raddr = maddr(b2_reg);
        endcase

        unique case (state_reg)
            S_FETCH: rf_raddr = mem_rdata[RF_AW-1:0];       // ra
            S_OPER:  rf_raddr = mem_rdata[7:8-RF_AW];       // rb
            default: rf_raddr = b2_reg[RF_AW-1:0];          // rc
        endcase

        mem_we    = 1'b0;
        mem_waddr = eo.mem_waddr;
        mem_wdata = eo.mem_wdata;
        if (state_reg == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end else if (quick && (in_cmd_reg == CMD_LOAD)) begin
            mem_we    = 1'b1;
            mem_waddr = maddr(in_addr_reg);
            mem_wdata = in_data_reg;
        end else if (exec_fire) begin
            mem_we    = eo.mem_we;
        end

        rf_we    = 1'b0;
        rf_waddr = eo.rf_waddr;
        rf_wdata = eo.rf_wdata;
        if (state_reg == S_CLEAR) begin
            rf_we    = 1'b1;
            rf_waddr = clr_cnt_reg[RF_AW-1:0];
            rf_wdata = '0;
        end else if (exec_fire) begin
            rf_we    = eo.rf_we;
        end

        if (exec_fire) begin
            res_tdata = {2'b00, eo.input_taken, eo.flags_next, eo.pc_next,
                         halt_reg | eo.halt_set, eo.char_out, eo.char_valid};
        end else begin
            res_tdata = {2'b00, 1'b0, flags_reg, pc_reg, halt_reg, 8'd0, 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            in_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            pc_reg       <= '0;
            sp_reg       <= SP_RESET;
            flags_reg    <= '0;
            halt_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (s_xfer) begin
                in_valid_reg <= 1'b1;
            end else if (quick || start) begin
                in_valid_reg <= 1'b0;
            end
            if (quick || exec_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (exec_fire) begin
                pc_reg    <= eo.pc_next;
                flags_reg <= eo.flags_next;
                halt_reg  <= halt_reg | eo.halt_set;
            end
            if (cfg_wr_en) begin
                sp_reg <= cfg_wr_data;
            end else if (exec_fire) begin
                sp_reg <= eo.sp_next;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_cmd_reg  <= s_tuser;
            in_addr_reg <= s_tdata[7:0];
            in_data_reg <= s_tdata[15:8];
        end
        if (start) begin
            data_reg <= in_data_reg;
        end
        if (state_reg == S_FETCH) begin
            b1_reg <= mem_rdata;
        end
        if (state_reg == S_OPER) begin
            b2_reg     <= mem_rdata;
            ra_val_reg <= rf_rdata;
        end
        if (state_reg == S_SRC) begin
            rb_val_reg <= rf_rdata;
            memd_reg   <= mem_rdata;
        end
        if (quick || exec_fire) begin
            m_tdata_reg <= res_tdata;
        end
    end

    // halt is sticky until reset
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $past(halt_reg) |-> halt_reg)
        else $error("halt flag dropped");

    // pc only moves at instruction write-back
    a_pc_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$past(exec_fire) |-> $stable(pc_reg))
        else $error("pc changed outside write-back");

    // write-back waits while the result register is still full
    a_exec_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC) && m_tvalid_reg && !m_tready |=> (state_reg == S_EXEC))
        else $error("write-back over a pending result");

    // no transfer accepted during the clearing sweep
    a_clear_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_tready)
        else $error("input accepted while clearing");

endmodule

`default_nettype wire
